// ----- sv/aes_pkg.sv -----
package aes_pkg;

  localparam int unsigned NR = 10;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned BLK_W = 128;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef logic [BLK_W-1:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NR] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] res;
    res = '0;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) begin
        res = 8'(i);
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of the block sits at bits [127-8k -: 8]
  function automatic logic [7:0] byte_at(input blk_t s, input int unsigned k);
    return s[BLK_W-1-8*k -: 8];
  endfunction

  function automatic blk_t sub_bytes(input blk_t s, input logic inv);
    blk_t t;
    for (int k = 0; k < 16; k++) begin
      t[BLK_W-1-8*k -: 8] = inv ? inv_sbox(byte_at(s, k)) : SBOX[byte_at(s, k)];
    end
    return t;
  endfunction

  function automatic blk_t shift_rows(input blk_t s, input logic inv);
    blk_t t;
    int unsigned src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        t[BLK_W-1-8*(r+4*c) -: 8] = byte_at(s, r + 4*src);
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s, input logic inv);
    blk_t t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j] = byte_at(s, j + 4*c);
        x2[j] = xtime(a[j]);
        x4[j] = xtime(x2[j]);
        x8[j] = xtime(x4[j]);
        m1[j] = a[j];
        m2[j] = x2[j];
        m3[j] = x2[j] ^ a[j];
        m9[j] = x8[j] ^ a[j];
        mb[j] = x8[j] ^ x2[j] ^ a[j];
        md[j] = x8[j] ^ x4[j] ^ a[j];
        me[j] = x8[j] ^ x4[j] ^ x2[j];
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[BLK_W-1-8*(r+4*c) -: 8] = me[r] ^ mb[(r+1)&3] ^ md[(r+2)&3] ^ m9[(r+3)&3];
        end else begin
          t[BLK_W-1-8*(r+4*c) -: 8] = m2[r] ^ m3[(r+1)&3] ^ m1[(r+2)&3] ^ m1[(r+3)&3];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic blk_t next_round_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    t = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- sv/aes_if.sv -----
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, command, data_high, data_low, input ready);
  modport sink (input valid, command, data_high, data_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

// ----- sv/aes128_block_cipher.sv -----
// Throughput: one request per cycle while round keys are ready and the output does not
// stall; eleven pipeline stages (initial key add, then one AES round each)
// and an output register, all advancing together on one stall enable. After reset or
// a key write, requests wait while the key is loaded as round key 0 and the key
// schedule unit derives round keys 1..10, one per cycle; in_ch.ready is low until then.
// Reset (rst_n, synchronous, active low) clears valid bits, key_r and key status.
module aes128_block_cipher
  import aes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  aes_in_if.sink               in_ch,
  aes_out_if.source            out_ch
);

  blk_t        key_r;
  blk_t        rk_r [NR+1];
  logic        keys_ready_r;
  logic        expanding_r;
  logic [3:0]  exp_cnt_r;

  logic        adv;
  logic        v_r   [NR+2];
  logic        cmd_r [NR];
  blk_t        st_r  [NR+2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      keys_ready_r <= 1'b0;
      expanding_r <= 1'b0;
      exp_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_r[127:64] <= cfg_data;
        REG_KEY_LOW:  key_r[63:0] <= cfg_data;
        default: ;
      endcase
      keys_ready_r <= 1'b0;
      expanding_r <= 1'b0;
    end else if (!keys_ready_r && !expanding_r) begin
      rk_r[0] <= key_r;
      expanding_r <= 1'b1;
      exp_cnt_r <= 4'd1;
    end else if (expanding_r) begin
      rk_r[exp_cnt_r] <= next_round_key(rk_r[exp_cnt_r - 4'd1], RCON[exp_cnt_r - 4'd1]);
      if (exp_cnt_r == 4'(NR)) begin
        expanding_r <= 1'b0;
        keys_ready_r <= 1'b1;
      end else begin
        exp_cnt_r <= exp_cnt_r + 4'd1;
      end
    end
  end

  assign adv = !v_r[NR+1] || out_ch.ready;
  assign in_ch.ready = adv && keys_ready_r;

  // stage 0: initial key add; stages 1..10: one round each; stage 11: output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NR+2; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_ch.valid && keys_ready_r;
      for (int i = 1; i < NR+2; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r[0] <= in_ch.command;
      st_r[0] <= {in_ch.data_high, in_ch.data_low} ^
                 (in_ch.command ? rk_r[NR] : rk_r[0]);
      for (int i = 1; i < NR; i++) cmd_r[i] <= cmd_r[i-1];
      for (int i = 1; i < NR+1; i++) begin
        if (cmd_r[i-1] == CMD_DECRYPT) begin
          if (i == NR) begin
            st_r[i] <= sub_bytes(shift_rows(st_r[i-1], 1'b1), 1'b1) ^ rk_r[0];
          end else begin
            st_r[i] <= mix_columns(sub_bytes(shift_rows(st_r[i-1], 1'b1), 1'b1)
                                   ^ rk_r[NR-i], 1'b1);
          end
        end else begin
          if (i == NR) begin
            st_r[i] <= shift_rows(sub_bytes(st_r[i-1], 1'b0), 1'b0) ^ rk_r[NR];
          end else begin
            st_r[i] <= mix_columns(shift_rows(sub_bytes(st_r[i-1], 1'b0), 1'b0), 1'b0)
                       ^ rk_r[i];
          end
        end
      end
      st_r[NR+1] <= st_r[NR];
    end
  end

  assign out_ch.valid = v_r[NR+1];
  assign out_ch.result_high = st_r[NR+1][127:64];
  assign out_ch.result_low = st_r[NR+1][63:0];

endmodule
